### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted
`define NPMT_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked implication, switched off while reset is asserted
`define NPMT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

`endif

### rtl/npmt_pkg.sv
// ---------------------------------------------------------------------------
// npmt_pkg
// Types, request codes and key constants of the position mark table.
// ---------------------------------------------------------------------------
`default_nettype none

package npmt_pkg;

	localparam int KEY_W   = 8;
	localparam int LINE_W  = 32;
	localparam int COL_W   = 16;
	localparam int REQ_W   = 3;
	localparam int ENTRY_W = KEY_W + LINE_W + COL_W;

	// request codes
	localparam logic [REQ_W-1:0] REQ_SET      = 3'd0;
	localparam logic [REQ_W-1:0] REQ_SET_CTX  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_GET      = 3'd2;
	localparam logic [REQ_W-1:0] REQ_CLR_ALL  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_CLR_LINE = 3'd4;

	// keys with a meaning of their own
	localparam logic [KEY_W-1:0] KEY_NUL       = 8'h00;
	localparam logic [KEY_W-1:0] KEY_APOSTROPHE = 8'h27;
	localparam logic [KEY_W-1:0] KEY_BACKQUOTE = 8'h60;

	// result of the shared compare unit
	typedef struct packed {
		logic key_hit;
		logic line_hit;
		logic free;
	} cmp_res_t;

	function automatic logic is_letter(input logic [KEY_W-1:0] k);
		return ((k >= 8'h41) && (k <= 8'h5A)) || ((k >= 8'h61) && (k <= 8'h7A));
	endfunction

	function automatic logic is_ctx_key(input logic [KEY_W-1:0] k);
		return (k == KEY_APOSTROPHE) || (k == KEY_BACKQUOTE);
	endfunction

endpackage

`default_nettype wire

### rtl/npmt_ram.sv
// ---------------------------------------------------------------------------
// npmt_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module npmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### rtl/npmt_cmp.sv
// ---------------------------------------------------------------------------
// npmt_cmp
// Shared compare unit: checks one stored slot against the request.
// ---------------------------------------------------------------------------
`default_nettype none

module npmt_cmp (
	input  logic [npmt_pkg::KEY_W-1:0]  slot_key,
	input  logic [npmt_pkg::LINE_W-1:0] slot_line,
	input  logic                        slot_valid,
	input  logic [npmt_pkg::KEY_W-1:0]  req_key,
	input  logic [npmt_pkg::LINE_W-1:0] req_line,
	output npmt_pkg::cmp_res_t          res
);

	import npmt_pkg::*;

	// key and line compares, gated by the slot being occupied
	always_comb begin
		res.key_hit  = slot_valid && (slot_key == req_key);
		res.line_hit = slot_valid && (slot_line == req_line);
		res.free     = !slot_valid;
	end

endmodule

`default_nettype wire

### rtl/named_position_mark_table.sv
// ---------------------------------------------------------------------------
// named_position_mark_table
// Associative table of one-letter marks to (line, column) positions.
// ---------------------------------------------------------------------------
// Usage:
//   A request beat is taken at a rising edge with start high and busy low.
//   Each request gives one result beat: done is high for exactly one cycle
//   with ok, mark_line and mark_column valid; the receiver cannot stall it.
//   Set-context, clear-all, context gets, NUL gets, non-letter sets and
//   unused codes finish at once: done is high in the cycle after the beat
//   and a new beat may be taken in that same cycle (one beat a cycle).
//   Set, plain get and clear-line walk the slot store one slot a cycle
//   through the single read port of the entry RAM and the shared compare
//   unit: busy is high until the cycle done rises, and done is registered
//   from the compare at the slot where the walk ends (a get or an update
//   stops at its hit).
//   Reset clears every slot valid bit and the context valid bit at once;
//   no clearing pass is needed and the block is ready straight after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module named_position_mark_table #(
	parameter int SLOT_COUNT = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [npmt_pkg::REQ_W-1:0]  req_type,
	input  logic [npmt_pkg::KEY_W-1:0]  key,
	input  logic [npmt_pkg::LINE_W-1:0] cursor_line,
	input  logic [npmt_pkg::COL_W-1:0]  cursor_column,
	output logic                        done,
	output logic                        ok,
	output logic [npmt_pkg::LINE_W-1:0] mark_line,
	output logic [npmt_pkg::COL_W-1:0]  mark_column
);

	import npmt_pkg::*;

	`include "assert_macros.svh"

	localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic             state_q;
	logic [IW-1:0]    idx_q;
	logic [REQ_W-1:0] req_q;
	logic [KEY_W-1:0] key_q;
	logic [LINE_W-1:0] line_q;
	logic [COL_W-1:0] col_q;
	logic             free_found_q;
	logic [IW-1:0]    free_idx_q;
	logic [SLOT_COUNT-1:0] valid_q;
	logic [LINE_W-1:0] ctx_line_q;
	logic [COL_W-1:0] ctx_col_q;
	logic             ctx_valid_q;
	logic             done_q;
	logic             ok_q;
	logic [LINE_W-1:0] mark_line_q;
	logic [COL_W-1:0] mark_column_q;

	logic             accept;
	logic             scan_req;
	logic             last;
	logic             in_scan;
	logic             ram_we;
	logic [IW-1:0]    ram_waddr;
	logic [IW-1:0]    ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [KEY_W-1:0] rd_key;
	logic [LINE_W-1:0] rd_line;
	logic [COL_W-1:0] rd_col;
	cmp_res_t         cmp;
	logic             done_d;
	logic             ok_d;
	logic [LINE_W-1:0] line_d;
	logic [COL_W-1:0] col_d;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign in_scan = (state_q == ST_SCAN);
	assign last    = (idx_q == LAST_IDX);

	// requests that need a walk over the slots
	assign scan_req = ((req_type == REQ_SET) && is_letter(key)) ||
		((req_type == REQ_GET) && (key != KEY_NUL) && !is_ctx_key(key)) ||
		(req_type == REQ_CLR_LINE);

	// entry store: key, line, column per slot
	assign ram_raddr = (in_scan && !last) ? (idx_q + IW'(1)) : '0;

	npmt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SLOT_COUNT),
		.AW    (IW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ({key_q, line_q, col_q}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign {rd_key, rd_line, rd_col} = ram_rdata;

	npmt_cmp u_cmp (
		.slot_key   (rd_key),
		.slot_line  (rd_line),
		.slot_valid (valid_q[idx_q]),
		.req_key    (key_q),
		.req_line   (line_q),
		.res        (cmp)
	);

	// set write: update on a hit, else take the first free slot at the end
	always_comb begin
		ram_we    = in_scan && (req_q == REQ_SET) &&
			(cmp.key_hit || (last && (free_found_q || cmp.free)));
		ram_waddr = (!cmp.key_hit && free_found_q) ? free_idx_q : idx_q;
	end

	// result of this cycle
	always_comb begin
		done_d = 1'b0;
		ok_d   = 1'b0;
		line_d = '0;
		col_d  = '0;
		if (accept && !scan_req) begin
			done_d = 1'b1;
			case (req_type)
				REQ_SET_CTX: ok_d = 1'b1;
				REQ_GET: begin
					if (is_ctx_key(key) && ctx_valid_q) begin
						ok_d   = 1'b1;
						line_d = ctx_line_q;
						col_d  = ctx_col_q;
					end
				end
				default: ok_d = 1'b0;
			endcase
		end else if (in_scan) begin
			case (req_q)
				REQ_GET: begin
					if (cmp.key_hit) begin
						done_d = 1'b1;
						ok_d   = 1'b1;
						line_d = rd_line;
						col_d  = rd_col;
					end else if (last) begin
						done_d = 1'b1;
					end
				end
				REQ_SET: begin
					if (cmp.key_hit || last) begin
						done_d = 1'b1;
						ok_d   = ram_we;
					end
				end
				default: done_d = last;
			endcase
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			req_q        <= REQ_SET;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			valid_q      <= '0;
			ctx_valid_q  <= 1'b0;
			done_q       <= 1'b0;
			ok_q         <= 1'b0;
		end else begin
			done_q <= done_d;
			ok_q   <= ok_d;
			if (accept) begin
				req_q        <= req_type;
				idx_q        <= '0;
				free_found_q <= 1'b0;
				if (scan_req) begin
					state_q <= ST_SCAN;
				end
				case (req_type)
					REQ_SET_CTX: ctx_valid_q <= 1'b1;
					REQ_CLR_ALL: begin
						valid_q     <= '0;
						ctx_valid_q <= 1'b0;
					end
					REQ_CLR_LINE: begin
						if (ctx_line_q == cursor_line) begin
							ctx_valid_q <= 1'b0;
						end
					end
					default: ;
				endcase
			end else if (in_scan) begin
				if (done_d) begin
					state_q <= ST_IDLE;
				end else begin
					idx_q <= idx_q + IW'(1);
				end
				if (!free_found_q && cmp.free) begin
					free_found_q <= 1'b1;
					free_idx_q   <= idx_q;
				end
				if ((req_q == REQ_CLR_LINE) && cmp.line_hit) begin
					valid_q[idx_q] <= 1'b0;
				end
				if (ram_we) begin
					valid_q[ram_waddr] <= 1'b1;
				end
			end
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q  <= key;
			line_q <= cursor_line;
			col_q  <= cursor_column;
			if (req_type == REQ_SET_CTX) begin
				ctx_line_q <= cursor_line;
				ctx_col_q  <= cursor_column;
			end
		end
		mark_line_q   <= line_d;
		mark_column_q <= col_d;
	end

	assign done        = done_q;
	assign ok          = ok_q;
	assign mark_line   = mark_line_q;
	assign mark_column = mark_column_q;

	// checks
	`NPMT_ASSERT_IMP(a_done_cause, clk, arst_n, done,
		$past(busy) || $past(start), "result beat without a request")
	`NPMT_ASSERT_IMP(a_idx_range, clk, arst_n, busy, idx_q <= LAST_IDX,
		"slot walk beyond the last slot")
	`NPMT_ASSERT_IMP(a_miss_zero, clk, arst_n, done && !ok,
		(mark_line == '0) && (mark_column == '0), "failed result with a position")
	`NPMT_ASSERT_IMP(a_clear_not_ok, clk, arst_n,
		done && ((req_q == REQ_CLR_ALL) || (req_q == REQ_CLR_LINE)), !ok,
		"clear request reported ok")

endmodule

`default_nettype wire
